@@ rtl/cpea_pkg.sv @@
// Package for the cubic polynomial expansion accumulator.
// Holds the sizes, codes, item types and state types shared by the front end, back end and top.
// Depends on nothing.
`default_nettype none

package cpea_pkg;

  localparam int VECT_SIZE = 16;
  localparam int EXP_SIZE = (VECT_SIZE + 3) * (VECT_SIZE + 2) * (VECT_SIZE + 1) / 6;

  localparam int FB_AW = (VECT_SIZE > 1) ? $clog2(VECT_SIZE) : 1;
  localparam int E_W = $clog2(VECT_SIZE + 1);
  localparam int SUM_AW = (EXP_SIZE > 1) ? $clog2(EXP_SIZE) : 1;

  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int PROD_SHIFT = 12;
  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_ACCUM = 2'd2,
    BK_DRAIN = 2'd3
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] feature_value;
    logic [9:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] sum_value;
    logic [19:0]        frame_count;
    logic               index_ok;
    logic               frames_dropped;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [15:0] feature;
    logic [9:0]         read_index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

`default_nettype wire

@@ rtl/cpea_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Used for the frame buffer copies and the monomial sums. No dependencies.
`default_nettype none

module cpea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/cpea_front.sv @@
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on cpea_pkg.
`default_nettype none

module cpea_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire cpea_pkg::in_item_t in_item,
  output logic                   in_full,
  output cpea_pkg::cmd_req_t     cmd_req,
  input  wire logic              cmd_take
);

  cpea_pkg::cmd_t q_r [cpea_pkg::Q_DEPTH];
  logic [cpea_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cpea_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cpea_pkg::Q_CW-1:0] cnt_r, cnt_nxt;
  logic                      accept;
  logic                      enq;
  logic                      deq;
  cpea_pkg::cmd_t            cmd_in;

  assign in_full = (cnt_r == cpea_pkg::Q_CW'(cpea_pkg::Q_DEPTH));
  assign accept = in_push && !in_full;

  always_comb begin
    cmd_in.feature = in_item.feature_value;
    cmd_in.read_index = in_item.read_index;
    cmd_in.kind = cpea_pkg::CMD_PUSH;
    enq = 1'b0;
    case (in_item.op)
      cpea_pkg::OP_PUSH: begin
        cmd_in.kind = cpea_pkg::CMD_PUSH;
        enq = accept;
      end
      cpea_pkg::OP_READ: begin
        cmd_in.kind = cpea_pkg::CMD_READ;
        enq = accept;
      end
      cpea_pkg::OP_CLEAR: begin
        cmd_in.kind = cpea_pkg::CMD_CLEAR;
        enq = accept;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  assign deq = cmd_take && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == cpea_pkg::Q_AW'(cpea_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == cpea_pkg::Q_AW'(cpea_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_req.valid = (cnt_r != '0);
  assign cmd_req.cmd = q_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ rtl/cpea_back.sv @@
// Back end: executes queued commands, buffers frames, runs the monomial
// accumulation pipeline and holds the result register. Depends on cpea_pkg, cpea_ram.
`default_nettype none

module cpea_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cpea_pkg::cmd_req_t cmd_req,
  output logic                    cmd_take,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output cpea_pkg::out_item_t     out_item
);

  localparam logic [cpea_pkg::E_W-1:0] E_LAST = cpea_pkg::E_W'(cpea_pkg::VECT_SIZE);

  cpea_pkg::back_state_t state_r, state_nxt;

  logic [cpea_pkg::FB_AW-1:0]   pos_r, pos_nxt;
  logic [cpea_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         drop_r, drop_nxt;
  logic                         live_r, live_nxt;
  logic [cpea_pkg::E_W-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [cpea_pkg::SUM_AW-1:0]  idx_r, idx_nxt;
  logic                         ok_r, ok_nxt;
  logic                         out_valid_r, out_valid_nxt;
  cpea_pkg::out_item_t          out_item_r;

  logic                         s1_v_r, s2_v_r, s3_v_r;
  logic [cpea_pkg::SUM_AW-1:0]  s1_idx_r, s2_idx_r, s3_idx_r;
  logic                         s1_i0_r, s1_j0_r, s1_k0_r;
  logic signed [31:0]           s2_pij_r;
  logic signed [15:0]           s2_ek_r;
  logic signed [47:0]           s3_p_r;

  logic cmd_take_c, fb_we, rd_issue, load_out, do_clear, step, fin;
  logic frame_last, start_acc, last_triple;

  logic [15:0] fb_i_rdata, fb_j_rdata, fb_k_rdata;
  logic signed [15:0] ei, ej, ek;
  logic [cpea_pkg::SUM_AW-1:0] sum_raddr;
  logic [63:0] sum_rdata;
  logic signed [63:0] addend;
  logic [63:0] sum_acc;

  assign frame_last = (pos_r == cpea_pkg::FB_AW'(cpea_pkg::VECT_SIZE - 1));
  assign start_acc = fb_we && frame_last && (count_r != cpea_pkg::COUNT_MAX);
  assign last_triple = (i_r == E_LAST) && (j_r == E_LAST) && (k_r == E_LAST);

  always_comb begin
    cmd_take_c = 1'b0;
    fb_we = 1'b0;
    rd_issue = 1'b0;
    load_out = 1'b0;
    do_clear = 1'b0;
    step = 1'b0;
    fin = 1'b0;
    case (state_r)
      cpea_pkg::BK_IDLE: begin
        if (cmd_req.valid) begin
          case (cmd_req.cmd.kind)
            cpea_pkg::CMD_PUSH: begin
              cmd_take_c = 1'b1;
              fb_we = 1'b1;
            end
            cpea_pkg::CMD_READ: begin
              if (!out_valid_r) begin
                cmd_take_c = 1'b1;
                rd_issue = 1'b1;
              end
            end
            cpea_pkg::CMD_CLEAR: begin
              cmd_take_c = 1'b1;
              do_clear = 1'b1;
            end
            default: begin
              cmd_take_c = 1'b1;
            end
          endcase
        end
      end
      cpea_pkg::BK_READ: begin
        load_out = 1'b1;
      end
      cpea_pkg::BK_ACCUM: begin
        step = 1'b1;
      end
      cpea_pkg::BK_DRAIN: begin
        fin = !(s1_v_r || s2_v_r || s3_v_r);
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpea_pkg::BK_IDLE: begin
        if (start_acc) begin
          state_nxt = cpea_pkg::BK_ACCUM;
        end else if (rd_issue) begin
          state_nxt = cpea_pkg::BK_READ;
        end
      end
      cpea_pkg::BK_READ: begin
        state_nxt = cpea_pkg::BK_IDLE;
      end
      cpea_pkg::BK_ACCUM: begin
        if (last_triple) begin
          state_nxt = cpea_pkg::BK_DRAIN;
        end
      end
      cpea_pkg::BK_DRAIN: begin
        if (fin) begin
          state_nxt = cpea_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = cpea_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    count_nxt = count_r;
    drop_nxt = drop_r;
    live_nxt = live_r;
    if (do_clear) begin
      pos_nxt = '0;
      count_nxt = '0;
      drop_nxt = 1'b0;
      live_nxt = 1'b0;
    end
    if (fb_we) begin
      if (frame_last) begin
        pos_nxt = '0;
        if (count_r == cpea_pkg::COUNT_MAX) begin
          drop_nxt = 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    if (fin) begin
      count_nxt = count_r + 1'b1;
      live_nxt = 1'b1;
    end
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    idx_nxt = idx_r;
    if (start_acc) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
      idx_nxt = '0;
    end else if (step) begin
      idx_nxt = idx_r + 1'b1;
      if (k_r != E_LAST) begin
        k_nxt = k_r + 1'b1;
      end else if (j_r != E_LAST) begin
        j_nxt = j_r + 1'b1;
        k_nxt = j_r + 1'b1;
      end else begin
        i_nxt = i_r + 1'b1;
        j_nxt = i_r + 1'b1;
        k_nxt = i_r + 1'b1;
      end
    end
  end

  assign ok_nxt = rd_issue ? (int'(cmd_req.cmd.read_index) < cpea_pkg::EXP_SIZE) : ok_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpea_pkg::BK_IDLE;
      pos_r <= '0;
      count_r <= '0;
      drop_r <= 1'b0;
      live_r <= 1'b0;
      out_valid_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      count_r <= count_nxt;
      drop_r <= drop_nxt;
      live_r <= live_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r <= step;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    idx_r <= idx_nxt;
    ok_r <= ok_nxt;
    s1_idx_r <= idx_r;
    s1_i0_r <= (i_r == '0);
    s1_j0_r <= (j_r == '0);
    s1_k0_r <= (k_r == '0);
    s2_idx_r <= s1_idx_r;
    s2_pij_r <= ei * ej;
    s2_ek_r <= ek;
    s3_idx_r <= s2_idx_r;
    s3_p_r <= s2_pij_r * s2_ek_r;
    if (load_out) begin
      out_item_r.sum_value <= (ok_r && live_r) ? signed'(sum_rdata) : '0;
      out_item_r.frame_count <= count_r;
      out_item_r.index_ok <= ok_r;
      out_item_r.frames_dropped <= drop_r;
    end
  end

  cpea_ram #(.WIDTH(16), .DEPTH(cpea_pkg::VECT_SIZE)) u_fb_i (
    .clk   (clk),
    .we    (fb_we),
    .waddr (pos_r),
    .wdata (cmd_req.cmd.feature),
    .raddr (cpea_pkg::FB_AW'(i_r - 1'b1)),
    .rdata (fb_i_rdata)
  );

  cpea_ram #(.WIDTH(16), .DEPTH(cpea_pkg::VECT_SIZE)) u_fb_j (
    .clk   (clk),
    .we    (fb_we),
    .waddr (pos_r),
    .wdata (cmd_req.cmd.feature),
    .raddr (cpea_pkg::FB_AW'(j_r - 1'b1)),
    .rdata (fb_j_rdata)
  );

  cpea_ram #(.WIDTH(16), .DEPTH(cpea_pkg::VECT_SIZE)) u_fb_k (
    .clk   (clk),
    .we    (fb_we),
    .waddr (pos_r),
    .wdata (cmd_req.cmd.feature),
    .raddr (cpea_pkg::FB_AW'(k_r - 1'b1)),
    .rdata (fb_k_rdata)
  );

  assign ei = s1_i0_r ? cpea_pkg::ONE_Q12 : signed'(fb_i_rdata);
  assign ej = s1_j0_r ? cpea_pkg::ONE_Q12 : signed'(fb_j_rdata);
  assign ek = s1_k0_r ? cpea_pkg::ONE_Q12 : signed'(fb_k_rdata);

  assign sum_raddr = (state_r == cpea_pkg::BK_IDLE) ?
                     cpea_pkg::SUM_AW'(cmd_req.cmd.read_index) : s2_idx_r;
  assign addend = 64'(s3_p_r >>> cpea_pkg::PROD_SHIFT);
  assign sum_acc = (live_r ? sum_rdata : 64'd0) + unsigned'(addend);

  cpea_ram #(.WIDTH(64), .DEPTH(cpea_pkg::EXP_SIZE)) u_sums (
    .clk   (clk),
    .we    (s3_v_r),
    .waddr (s3_idx_r),
    .wdata (sum_acc),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign cmd_take = cmd_take_c;
  assign out_empty = !out_valid_r;
  assign out_item = out_item_r;

endmodule

`default_nettype wire

@@ rtl/cubic_poly_expansion_accumulator_top.sv @@
// Top level of the cubic polynomial expansion accumulator.
// Connects the front end (classify and queue) to the back end (execute).
// Depends on cpea_pkg, cpea_front, cpea_back.
//
// Input items enter through in_push/in_full: op 0 pushes one signed Q3.12 feature
// element, op 1 reads one monomial sum with the frame count and status, op 2
// clears, op 3 is dropped. A four-entry command queue decouples the input from
// the executing back end, so items are taken while the back end is busy.
// A push writes one element into the frame buffer. The push that completes a frame
// starts the monomial sweep: one triple per cycle through a three-stage multiply
// pipeline into the sums RAM, EXP_SIZE triples in all, then a drain of the pipeline.
// If the frame count is saturated, the frame is dropped and the drop flag is set.
// A read is taken from the queue in the idle state with its sums RAM read issued;
// its result is registered into out_item from the read state that follows.
// A clear needs no sweep of the sums RAM: a live flag marks the sums as zero until
// the first frame has been added. Results wait in one output register while
// out_empty is low; until it is popped a further read waits at the head of the
// queue and holds the items behind it.
// Synchronous reset empties the queue and the result register and makes the sums,
// count and drop flag read as zero; the block takes items right after reset.
`default_nettype none

module cubic_poly_expansion_accumulator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire cpea_pkg::in_item_t in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output cpea_pkg::out_item_t     out_item
);

  cpea_pkg::cmd_req_t cmd_req;
  logic               cmd_take;

  cpea_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_req  (cmd_req),
    .cmd_take (cmd_take)
  );

  cpea_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_req   (cmd_req),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_req.valid)
    else $error("Back end took a command from an empty queue.");

  a_bad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.index_ok) |-> (out_item.sum_value == 64'sd0))
    else $error("Out-of-range read returned a nonzero sum.");

  a_drop_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.frames_dropped) |-> (out_item.frame_count == cpea_pkg::COUNT_MAX))
    else $error("Dropped-frame flag set while the frame count is not saturated.");

endmodule

`default_nettype wire
